/* hdl/rhh_pkg.sv */
// Shared constants and types for the RGB to HSL / HSV pixel unit.
`timescale 1ns / 1ps
package rhh_pkg;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_HSL  = 2'd1,
    MODE_HSV  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  localparam int CH_W     = 16;
  localparam int DIV_W    = 34;              // widest dividend: 2*65535*d + den
  localparam int QUO_W    = 16;              // quotient bits, one per divider stage
  localparam logic [CH_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [16:0]     TWO_FULL   = 17'd131070;

endpackage

/* hdl/rgb_to_hsl_hsv_pixel_unit.sv */
// Pipelined RGB to HSL / HSV pixel unit with mode register.
// Throughput: one pixel per cycle while the output is not stalled; the 16-stage
// restoring divider lanes (one quotient bit per stage) take a new dividend every
// cycle under the same condition.
// A stall on the output freezes every stage together; nothing is lost or repeated.
// Reset (rst, synchronous) clears the valid bits and sets the mode to pass through.
`timescale 1ns / 1ps
module rgb_to_hsl_hsv_pixel_unit
  import rhh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // red_in, green_in, blue_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // first_channel, second_channel, third_channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // conversion_mode in bits 1:0
);

  localparam int NSTG = QUO_W;

  mode_t mode;
  logic  adv;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PASS;
    end else if (cfg_valid) begin
      mode <= mode_t'(cfg_data[1:0]);
    end
  end

  // stage 1: max and min
  logic            v1_ok;
  logic [1:0]      v1_kind;          // 1 HSL, 2 HSV, 0 pass
  logic [CH_W-1:0] r1, g1, b1, mx1, mn1;

  logic [CH_W-1:0] r_in, g_in, b_in, mx_rg, mn_rg;
  assign r_in  = s_tdata[15:0];
  assign g_in  = s_tdata[31:16];
  assign b_in  = s_tdata[47:32];
  assign mx_rg = (r_in > g_in) ? r_in : g_in;
  assign mn_rg = (r_in < g_in) ? r_in : g_in;

  always_ff @(posedge clk) begin
    if (rst) v1_ok <= 1'b0;
    else if (adv) v1_ok <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1  <= r_in;
      g1  <= g_in;
      b1  <= b_in;
      mx1 <= (mx_rg > b_in) ? mx_rg : b_in;
      mn1 <= (mn_rg < b_in) ? mn_rg : b_in;
      case (mode)
        MODE_HSL: v1_kind <= 2'd1;
        MODE_HSV: v1_kind <= 2'd2;
        default:  v1_kind <= 2'd0;
      endcase
    end
  end

  // stage 2: difference, divisor, hue numerator, third channel
  logic            v2_ok, zero2;
  logic [1:0]      v2_kind;
  logic [CH_W-1:0] p0_2, p1_2, ch2_2, d2, den2;
  logic [18:0]     num2;

  logic [CH_W-1:0] d_c, den_c, ch2_c;
  logic [16:0]     sum_c, sum1_c, rem_c;
  logic [18:0]     num_c, d19;

  always_comb begin
    d_c    = mx1 - mn1;
    sum_c  = {1'b0, mx1} + {1'b0, mn1};
    sum1_c = sum_c + 17'd1;
    rem_c  = TWO_FULL - sum_c;
    d19    = {3'b000, d_c};
    num_c  = '0;
    den_c  = mx1;
    ch2_c  = b1;
    if (v1_kind == 2'd1) begin
      den_c = (sum_c <= {1'b0, FULL_SCALE}) ? sum_c[15:0] : rem_c[15:0];
      ch2_c = sum1_c[16:1];
      if (r1 == mx1) begin
        num_c = (g1 == mn1) ? 19'd5 * d19 + {3'b000, mx1 - b1}
                            : d19 - {3'b000, mx1 - g1};
      end else if (g1 == mx1) begin
        num_c = (b1 == mn1) ? d19 + {3'b000, mx1 - r1}
                            : 19'd3 * d19 - {3'b000, mx1 - b1};
      end else begin
        num_c = (r1 == mn1) ? 19'd3 * d19 + {3'b000, mx1 - g1}
                            : 19'd5 * d19 - {3'b000, mx1 - r1};
      end
    end else if (v1_kind == 2'd2) begin
      ch2_c = mx1;
      if (r1 == mx1) begin
        num_c = (g1 >= b1) ? {3'b000, g1 - b1} : 19'd6 * d19 - {3'b000, b1 - g1};
      end else if (g1 == mx1) begin
        num_c = 19'd2 * d19 + {3'b000, b1} - {3'b000, r1};
      end else begin
        num_c = 19'd4 * d19 + {3'b000, r1} - {3'b000, g1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2_ok <= 1'b0;
    else if (adv) v2_ok <= v1_ok;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v2_kind <= v1_kind;
      p0_2    <= r1;
      p1_2    <= g1;
      ch2_2   <= ch2_c;
      d2      <= d_c;
      den2    <= den_c;
      num2    <= num_c;
      zero2   <= (d_c == '0);
    end
  end

  // divider lanes: index 0 holds the rounded dividend and doubled divisor
  logic            dv_ok   [0:NSTG];
  logic [1:0]      dv_kind [0:NSTG];
  logic            dv_zero [0:NSTG];
  logic [CH_W-1:0] dv_p0   [0:NSTG];
  logic [CH_W-1:0] dv_p1   [0:NSTG];
  logic [CH_W-1:0] dv_ch2  [0:NSTG];
  logic [DIV_W-1:0] sr     [0:NSTG];   // saturation remainder
  logic [DIV_W-1:0] hr     [0:NSTG];   // hue remainder
  logic [16:0]      sd     [0:NSTG];
  logic [16:0]      hd     [0:NSTG];
  logic [QUO_W-1:0] sq     [0:NSTG];
  logic [QUO_W-1:0] hq     [0:NSTG];

  logic [DIV_W-1:0] sn_c, hn_c;
  assign sn_c = DIV_W'({1'b0, FULL_SCALE}) * DIV_W'({d2, 1'b0}) + DIV_W'(den2);
  assign hn_c = DIV_W'(num2) * DIV_W'(8'd120) + DIV_W'(d2);

  always_ff @(posedge clk) begin
    if (rst) dv_ok[0] <= 1'b0;
    else if (adv) dv_ok[0] <= v2_ok;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_kind[0] <= v2_kind;
      dv_zero[0] <= zero2;
      dv_p0[0]   <= p0_2;
      dv_p1[0]   <= p1_2;
      dv_ch2[0]  <= ch2_2;
      sr[0]      <= sn_c;
      hr[0]      <= hn_c;
      sd[0]      <= {den2, 1'b0};
      hd[0]      <= {d2, 1'b0};
      sq[0]      <= '0;
      hq[0]      <= '0;
    end
  end

  logic [DIV_W-1:0] ss_c [0:NSTG-1];
  logic [DIV_W-1:0] hs_c [0:NSTG-1];

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      ss_c[i] = DIV_W'(sd[i]) << (NSTG - 1 - i);
      hs_c[i] = DIV_W'(hd[i]) << (NSTG - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NSTG; i++) dv_ok[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 1; i <= NSTG; i++) dv_ok[i] <= dv_ok[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= NSTG; i++) begin
        dv_kind[i] <= dv_kind[i-1];
        dv_zero[i] <= dv_zero[i-1];
        dv_p0[i]   <= dv_p0[i-1];
        dv_p1[i]   <= dv_p1[i-1];
        dv_ch2[i]  <= dv_ch2[i-1];
        sd[i]      <= sd[i-1];
        hd[i]      <= hd[i-1];
        if (sr[i-1] >= ss_c[i-1]) begin
          sr[i] <= sr[i-1] - ss_c[i-1];
          sq[i] <= {sq[i-1][QUO_W-2:0], 1'b1};
        end else begin
          sr[i] <= sr[i-1];
          sq[i] <= {sq[i-1][QUO_W-2:0], 1'b0};
        end
        if (hr[i-1] >= hs_c[i-1]) begin
          hr[i] <= hr[i-1] - hs_c[i-1];
          hq[i] <= {hq[i-1][QUO_W-2:0], 1'b1};
        end else begin
          hr[i] <= hr[i-1];
          hq[i] <= {hq[i-1][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= dv_ok[NSTG];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_kind[NSTG] == 2'd0) begin
        m_tdata <= {dv_ch2[NSTG], dv_p1[NSTG], dv_p0[NSTG]};
      end else if (dv_zero[NSTG]) begin
        m_tdata <= {dv_ch2[NSTG], 32'd0};
      end else begin
        m_tdata <= {dv_ch2[NSTG], sq[NSTG], hq[NSTG]};
      end
    end
  end

endmodule

/* tb/sv/rgb_to_hsl_hsv_pixel_unit_test.sv */
// Self-checking bench for the RGB to HSL / HSV pixel unit.
`timescale 1ns / 1ps
module rgb_to_hsl_hsv_pixel_unit_test
  import rhh_pkg::*;
;

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
  } chans_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  int errors = 0;
  int idle_cycles = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  bit hold_rx = 1'b0;
  bit done = 1'b0;
  bit [3:0] modes_seen = '0;

  always #10 clk = ~clk;

  rgb_to_hsl_hsv_pixel_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] rdiv(input logic [63:0] num, input logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic chans_t convert_pixel(input mode_t mode, input logic [15:0] r,
                                           input logic [15:0] g, input logic [15:0] b);
    chans_t o;
    logic [63:0] v, m, d, sum, num;
    v = (r > g) ? r : g;
    v = (v > b) ? v : b;
    m = (r < g) ? r : g;
    m = (m < b) ? m : b;
    d = v - m;
    sum = v + m;
    o = '{r, g, b};
    if (mode == MODE_HSL) begin
      o = '{16'd0, 16'd0, 16'((sum + 1) >> 1)};
      if (sum != 0 && d != 0) begin
        o.c1 = (sum <= 65535) ? 16'(rdiv(65535 * d, sum)) : 16'(rdiv(65535 * d, 131070 - sum));
        if (r == v) num = (g == m) ? 5 * d + (v - b) : d - (v - g);
        else if (g == v) num = (b == m) ? d + (v - r) : 3 * d - (v - b);
        else num = (r == m) ? 3 * d + (v - g) : 5 * d - (v - r);
        o.c0 = 16'(rdiv(60 * num, d));
      end
    end else if (mode == MODE_HSV) begin
      o = '{16'd0, 16'd0, 16'(v)};
      if (d != 0) begin
        o.c1 = 16'(rdiv(65535 * d, v));
        if (r == v) num = (g >= b) ? 64'(g - b) : 6 * d - (b - g);
        else if (g == v) num = 2 * d + b - r;
        else num = 4 * d + r - g;
        o.c0 = 16'(rdiv(60 * num, d));
      end
    end
    return o;
  endfunction

  class pixel_scoreboard;
    chans_t pending[$];
    mode_t mode = MODE_PASS;
    function void note_pixel(logic [47:0] px);
      pending.push_back(convert_pixel(mode, px[15:0], px[31:16], px[47:32]));
    endfunction
    task check_result(logic [47:0] res);
      chans_t want;
      if (pending.size() == 0) begin
        $display("unexpected result %h at %0t", res, $realtime);
        errors++;
      end else begin
        want = pending.pop_front();
        if (res[15:0] != want.c0) report_mismatch("first_channel", res[15:0], want.c0);
        if (res[31:16] != want.c1) report_mismatch("second_channel", res[31:16], want.c1);
        if (res[47:32] != want.c2) report_mismatch("third_channel", res[47:32], want.c2);
      end
    endtask
  endclass

  pixel_scoreboard sb = new();

  // sample at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_pixel(s_tdata);
        pixels_sent++;
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        results_seen++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("watchdog expired");
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    while (!done) begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
      end
      w = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // valid stays high after a request so that the next one can follow at once
  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 15) : 0;
    if (w != 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic set_mode(input mode_t mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= {6'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode = (mode == MODE_RSVD) ? MODE_PASS : mode;
    modes_seen[mode] = 1'b1;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic directed_set();
    send_pixel(0, 0, 0, 0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 0);
    send_pixel(16'hFFFF, 0, 0, 0);
    send_pixel(0, 16'hFFFF, 0, 0);
    send_pixel(0, 0, 16'hFFFF, 0);
    send_pixel(16'hFFFF, 16'hFFFF, 0, 0);
    send_pixel(16'hFFFF, 0, 16'hFFFF, 0);
    send_pixel(0, 16'hFFFF, 16'hFFFF, 0);
    send_pixel(16'hFFFF, 0, 1, 0);      // hue just below a full turn
    send_pixel(1, 0, 0, 0);
    send_pixel(16'h5555, 16'hAAAA, 16'h1234, 0);
  endtask

  initial begin
    mode_t m;
    logic [15:0] r, g, b;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_set();                     // reset mode: pass through
    set_mode(MODE_HSL);
    directed_set();
    set_mode(MODE_HSV);
    directed_set();
    set_mode(MODE_RSVD);
    directed_set();
    for (int ph = 0; ph < 6; ph++) begin
      m = mode_t'(ph % 3);
      if (ph == 3) m = MODE_HSL;
      set_mode(m);
      if (ph == 2) hold_rx = 1'b1;      // back-pressure fills the pipeline
      for (int i = 0; i < 120; i++) begin
        r = rand_sample();
        g = rand_sample();
        b = rand_sample();
        if ($urandom_range(0, 7) == 0) g = r;
        if ($urandom_range(0, 7) == 0) b = r;
        send_pixel(r, g, b, ph != 2 && $urandom_range(0, 3) != 0);
      end
    end
    drain();
    done = 1'b1;
    $display("%0d pixels sent, %0d results checked, modes written %b",
             pixels_sent, results_seen, modes_seen);
    $display("directed extremes per mode, random pixels with stalls and long hold-off");
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
